// ===== design/sslw_pkg.sv =====
package sslw_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_BIT_FALL = 4'd5,
    PH_ACK_WAIT = 4'd6,
    PH_ACK_HIGH = 4'd7,
    PH_STOP_A   = 4'd8,
    PH_STOP_B   = 4'd9,
    PH_STOP_C   = 4'd10,
    PH_STOP_D   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    FR_DATA_CMD = 2'd0,
    FR_ADDR     = 2'd1,
    FR_SEGS     = 2'd2,
    FR_CTRL     = 2'd3
  } frame_t;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CTRL = 2'd1;
  localparam logic [1:0] REQ_RAW  = 2'd2;
  localparam logic [1:0] REQ_HEX  = 2'd3;

  localparam logic [1:0] CFG_DISPLAY_ON  = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS  = 2'd1;
  localparam logic [1:0] CFG_PHASE_TICKS = 2'd2;

  localparam logic [7:0] DATA_CMD  = 8'h40;
  localparam logic [7:0] ADDR_BASE = 8'hC0;
  localparam logic [7:0] DOT_MASK  = 8'h20;
  localparam logic [7:0] CTRL_BASE = 8'h80;
  localparam logic [7:0] ON_MASK   = 8'h08;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] position;
    logic [7:0] value;
    logic       add_dot;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_out;
    logic sda_out;
    logic busy_res;
    logic accepted;
  } out_item_t;

  function automatic logic [7:0] hex_segments(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Wire levels {clock, data} driven while a phase lasts
  function automatic logic [1:0] phase_levels(input phase_t ph, input logic b);
    logic [1:0] lv;
    unique case (ph)
      PH_START_B:  lv = 2'b10;
      PH_BIT_LOW:  lv = {1'b0, b};
      PH_BIT_HIGH: lv = {1'b1, b};
      PH_BIT_FALL: lv = {1'b0, b};
      PH_ACK_WAIT: lv = 2'b01;
      PH_STOP_A:   lv = 2'b01;
      PH_STOP_B:   lv = 2'b00;
      PH_STOP_C:   lv = 2'b10;
      default:     lv = 2'b11;
    endcase
    return lv;
  endfunction

endpackage

// ===== design/sslw_ifs.sv =====
interface sslw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [2:0] position;
  logic [7:0] value;
  logic       add_dot;
  logic       sda_in;

  modport source (output valid, req_type, position, value, add_dot, sda_in, input ready);
  modport sink (input valid, req_type, position, value, add_dot, sda_in, output ready);
endinterface

interface sslw_out_if;
  logic valid;
  logic ready;
  logic scl_out;
  logic sda_out;
  logic busy_res;
  logic accepted;

  modport source (output valid, scl_out, sda_out, busy_res, accepted, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, accepted, output ready);
endinterface

interface sslw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/sslw_seq.sv =====
module sslw_seq #(
  parameter int NUM_POSITIONS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  sslw_pkg::in_item_t item,
  input  logic               display_on,
  input  logic [2:0]         brightness,
  input  logic [15:0]        phase_ticks,
  output sslw_pkg::out_item_t result
);
  import sslw_pkg::*;

  localparam logic [3:0] NUM_POS = 4'(NUM_POSITIONS);

  phase_t      phase_r, phase_nxt;
  frame_t      frame_r, frame_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] div_r, div_nxt;
  logic [2:0]  hpos_r, hpos_nxt;
  logic [7:0]  hseg_r, hseg_nxt;
  logic [1:0]  wires_r, wires_nxt;

  logic [15:0] lim;
  logic [1:0]  drive;
  logic        acc;
  logic        adv;
  phase_t      nph;

  assign lim = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      frame_r <= FR_DATA_CMD;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      div_r   <= 16'd0;
      hpos_r  <= 3'd0;
      hseg_r  <= 8'd0;
      wires_r <= 2'b11;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      frame_r <= frame_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      div_r   <= div_nxt;
      hpos_r  <= hpos_nxt;
      hseg_r  <= hseg_nxt;
      wires_r <= wires_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    frame_nxt = frame_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    div_nxt   = div_r;
    hpos_nxt  = hpos_r;
    hseg_nxt  = hseg_r;
    wires_nxt = wires_r;
    acc       = 1'b0;
    adv       = 1'b0;
    nph       = PH_IDLE;

    // take a request while idle; the start phase begins on this tick
    if (phase_r == PH_IDLE && item.req_type != REQ_TICK) begin
      if (item.req_type == REQ_CTRL) begin
        hseg_nxt  = CTRL_BASE | (display_on ? ON_MASK : 8'h00) | {5'd0, brightness};
        frame_nxt = FR_CTRL;
        shift_nxt = hseg_nxt;
        acc       = 1'b1;
      end else if ({1'b0, item.position} < NUM_POS) begin
        hpos_nxt = item.position;
        if (item.req_type == REQ_RAW) begin
          hseg_nxt = item.value;
        end else begin
          hseg_nxt = hex_segments(item.value[3:0]) | (item.add_dot ? DOT_MASK : 8'h00);
        end
        frame_nxt = FR_DATA_CMD;
        shift_nxt = DATA_CMD;
        acc       = 1'b1;
      end
      if (acc) begin
        bit_nxt   = 4'd0;
        phase_nxt = PH_START_A;
        div_nxt   = 16'd0;
        wires_nxt = phase_levels(PH_START_A, shift_nxt[0]);
      end
    end

    drive = wires_nxt;

    if (phase_nxt == PH_ACK_WAIT) begin
      adv = !item.sda_in;
    end else if (phase_nxt != PH_IDLE) begin
      div_nxt = div_nxt + 16'd1;
      adv     = (div_nxt >= lim);
    end

    if (adv) begin
      unique case (phase_nxt)
        PH_START_A:  nph = PH_START_B;
        PH_START_B: begin
          bit_nxt = 4'd0;
          nph     = PH_BIT_LOW;
        end
        PH_BIT_LOW:  nph = PH_BIT_HIGH;
        PH_BIT_HIGH: nph = PH_BIT_FALL;
        PH_BIT_FALL: begin
          bit_nxt   = bit_nxt + 4'd1;
          shift_nxt = {1'b0, shift_nxt[7:1]};
          nph       = (bit_nxt >= 4'd8) ? PH_ACK_WAIT : PH_BIT_LOW;
        end
        PH_ACK_WAIT: nph = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          if (frame_nxt == FR_ADDR) begin
            frame_nxt = FR_SEGS;
            shift_nxt = hseg_nxt;
            bit_nxt   = 4'd0;
            nph       = PH_BIT_LOW;
          end else begin
            nph = PH_STOP_A;
          end
        end
        PH_STOP_A:   nph = PH_STOP_B;
        PH_STOP_B:   nph = PH_STOP_C;
        PH_STOP_C:   nph = PH_STOP_D;
        PH_STOP_D: begin
          // after the data command, go on with the address frame
          if (frame_nxt == FR_DATA_CMD) begin
            frame_nxt = FR_ADDR;
            shift_nxt = ADDR_BASE | {5'd0, hpos_nxt};
            nph       = PH_START_A;
          end else begin
            nph = PH_IDLE;
          end
        end
        default:     nph = PH_IDLE;
      endcase
      phase_nxt = nph;
      div_nxt   = 16'd0;
      wires_nxt = phase_levels(nph, shift_nxt[0]);
    end

    result.scl_out  = drive[1];
    result.sda_out  = drive[0];
    result.busy_res = (phase_nxt != PH_IDLE);
    result.accepted = acc;
  end

  a_acc_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && acc |-> phase_r == PH_IDLE)
    else $error("request taken while a transaction runs");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && acc |=> phase_r != PH_IDLE)
    else $error("sequencer idle right after taking a request");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> wires_r == 2'b11)
    else $error("wires not released while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8)
    else $error("bit counter past eight");

endmodule

// ===== design/seven_segment_serial_link_writer_core.sv =====
// The result of a tick transfer is offered on the out channel from the result buffer.
// Throughput: one tick per cycle unless the buffer is full; the wire sequencer does
// all its work for a tick combinationally; a two-entry buffer absorbs output stalls.
// Reset (rst_n low at a clock edge): sequencer idle with both wires released,
// result buffer empty, display_on 1, brightness 7, phase_ticks 1.
module seven_segment_serial_link_writer_core #(
  parameter int NUM_POSITIONS = 6
) (
  input logic        clk,
  input logic        rst_n,
  sslw_in_if.sink    in_if,
  sslw_out_if.source out_if,
  sslw_cfg_if.sink   cfg_if
);
  import sslw_pkg::*;

  logic        display_on_r;
  logic [2:0]  brightness_r;
  logic [15:0] phase_ticks_r;

  in_item_t    item;
  out_item_t   res;
  out_item_t   buf0_r, buf0_nxt;
  out_item_t   buf1_r, buf1_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_on_r  <= 1'b1;
      brightness_r  <= 3'd7;
      phase_ticks_r <= 16'd1;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_DISPLAY_ON:  display_on_r  <= cfg_if.data[0];
        CFG_BRIGHTNESS:  brightness_r  <= cfg_if.data[2:0];
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign item.req_type = in_if.req_type;
  assign item.position = in_if.position;
  assign item.value    = in_if.value;
  assign item.add_dot  = in_if.add_dot;
  assign item.sda_in   = in_if.sda_in;

  assign in_if.ready = (count_r != 2'd2);
  assign push = in_if.valid && in_if.ready;
  assign pop  = out_if.valid && out_if.ready;

  sslw_seq #(
    .NUM_POSITIONS(NUM_POSITIONS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (push),
    .item        (item),
    .display_on  (display_on_r),
    .brightness  (brightness_r),
    .phase_ticks (phase_ticks_r),
    .result      (res)
  );

  // result buffer: entry 0 is the head
  always_comb begin
    buf0_nxt  = buf0_r;
    buf1_nxt  = buf1_r;
    count_nxt = count_r;
    unique case (count_r)
      2'd0: begin
        if (push) begin
          buf0_nxt  = res;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          buf0_nxt = res;
        end else if (pop) begin
          count_nxt = 2'd0;
        end else if (push) begin
          buf1_nxt  = res;
          count_nxt = 2'd2;
        end
      end
      default: begin
        if (pop) begin
          buf0_nxt  = buf1_r;
          count_nxt = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  assign out_if.valid    = (count_r != 2'd0);
  assign out_if.scl_out  = buf0_r.scl_out;
  assign out_if.sda_out  = buf0_r.sda_out;
  assign out_if.busy_res = buf0_r.busy_res;
  assign out_if.accepted = buf0_r.accepted;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("result buffer lost a transfer");

  a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 2'd1)
    else $error("result buffer repeated a transfer");

endmodule
